// ===== rtl/core/bpc_pkg.sv =====
// Shared types and constants for the barometric compensation core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned RawW = 20;
  localparam int unsigned WordW = 64;
  localparam int unsigned DivSteps = 64;

  // Register indexes of the configuration channel
  localparam logic [CfgIdxW-1:0] CFG_T1       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_T2       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_T3       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_P_FIRST  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_P_MIDDLE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_P_LAST   = 3'd5;

  localparam logic signed [33:0] FineOffset = 34'sd128000;
  localparam logic [20:0] PresFull = 21'h100000;
  localparam logic [63:0] PresScale = 64'd3125;

  // Unpacked calibration coefficients
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } bpc_cal_t;

  // One beat moving along the divider cells
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic        fault;
    logic [31:0] temp;
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
  } bpc_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpc_front.sv =====
// Front pipeline: temperature path and pressure numerator/denominator.
// Depends on bpc_pkg; feeds the first divider cell.
`default_nettype none

module bpc_front
  import bpc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [RawW-1:0] raw_t_i,
  input  wire logic [RawW-1:0] raw_p_i,
  input  wire bpc_cal_t        cal_i,
  output bpc_div_t             head_o
);

  logic [8:0] vld_q;

  logic [31:0] pa_q, bb_q, v1t_q, xt3_q;
  logic [31:0] temp3_q, temp4_q, temp5_q, temp6_q, temp7_q, temp8_q;
  logic [RawW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [33:0] v1_q;
  logic [63:0] sq_q, m5_q, m2_q;
  logic [63:0] m6_q, m3_q, m5b_q, m2b_q;
  logic [63:0] v2_q, v1b_q, v1c_q, n0_q, den_q, num_q;
  logic        fault_q, neg_q;
  logic [63:0] anum_q, aden_q;

  logic [31:0] a_s, b_s, x_s, fine_s;
  logic [20:0] pu_s;

  always_comb begin
    a_s    = 32'(raw_t_i[19:3]) - {15'd0, cal_i.t1, 1'b0};
    b_s    = 32'(raw_t_i[19:4]) - 32'(cal_i.t1);
    x_s    = 32'($signed(bb_q) >>> 12);
    fine_s = v1t_q + 32'($signed(xt3_q) >>> 14);
    pu_s   = PresFull - {1'b0, p6_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // temperature products
    pa_q    <= a_s * 32'(cal_i.t2);
    bb_q    <= b_s * b_s;
    p1_q    <= raw_p_i;
    v1t_q   <= 32'($signed(pa_q) >>> 11);
    xt3_q   <= x_s * 32'(cal_i.t3);
    p2_q    <= p1_q;
    temp3_q <= 32'($signed((fine_s << 2) + fine_s + 32'd128) >>> 8);
    v1_q    <= 34'($signed(fine_s)) - FineOffset;
    p3_q    <= p2_q;
    // pressure denominator and offset terms
    sq_q    <= 64'(v1_q) * 64'(v1_q);
    m5_q    <= 64'(v1_q) * 64'(cal_i.p5);
    m2_q    <= 64'(v1_q) * 64'(cal_i.p2);
    temp4_q <= temp3_q;
    p4_q    <= p3_q;
    m6_q    <= sq_q * 64'(cal_i.p6);
    m3_q    <= sq_q * 64'(cal_i.p3);
    m5b_q   <= m5_q;
    m2b_q   <= m2_q;
    temp5_q <= temp4_q;
    p5_q    <= p4_q;
    v2_q    <= m6_q + (m5b_q << 17) + (64'(cal_i.p4) << 35);
    v1b_q   <= 64'($signed(m3_q) >>> 8) + (m2b_q << 12);
    temp6_q <= temp5_q;
    p6_q    <= p5_q;
    v1c_q   <= ((64'd1 << 47) + v1b_q) * 64'(cal_i.p1);
    n0_q    <= ({43'd0, pu_s} << 31) - v2_q;
    temp7_q <= temp6_q;
    den_q   <= 64'($signed(v1c_q) >>> 33);
    num_q   <= n0_q * PresScale;
    temp8_q <= temp7_q;
    // magnitudes and quotient sign for the divider
    anum_q  <= num_q[63] ? 64'd0 - num_q : num_q;
    aden_q  <= den_q[63] ? 64'd0 - den_q : den_q;
    neg_q   <= num_q[63] ^ den_q[63];
    fault_q <= (den_q == 64'd0);
  end

  // temperature leaves stage 8 in lockstep with the magnitudes
  logic [31:0] temp9_q;
  always_ff @(posedge clk_i) begin
    temp9_q <= temp8_q;
  end

  always_comb begin
    head_o.valid = vld_q[8];
    head_o.neg   = neg_q;
    head_o.fault = fault_q;
    head_o.temp  = temp9_q;
    head_o.rem   = '0;
    head_o.num   = anum_q;
    head_o.den   = aden_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpc_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per beat.
// Depends on bpc_pkg for the beat type.
`default_nettype none

module bpc_div_cell
  import bpc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bpc_div_t beat_i,
  output bpc_div_t      beat_o
);

  logic        valid_q;
  bpc_div_t    data_d;
  bpc_div_t    data_q;
  logic [63:0] shifted_s;
  logic        ge_s;

  // quotient bits fill the dividend bits as they are consumed
  always_comb begin
    shifted_s   = {beat_i.rem[62:0], beat_i.num[63]};
    ge_s        = (shifted_s >= beat_i.den);
    data_d      = beat_i;
    data_d.rem  = ge_s ? shifted_s - beat_i.den : shifted_s;
    data_d.num  = {beat_i.num[62:0], ge_s};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    beat_o       = data_q;
    beat_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpc_back.sv =====
// Back pipeline: quotient sign, second-order pressure terms, saturation.
// Depends on bpc_pkg; takes the last divider cell's beat.
`default_nettype none

module bpc_back
  import bpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bpc_div_t    beat_i,
  input  wire bpc_cal_t    cal_i,
  output logic             valid_o,
  output logic [31:0]      temp_o,
  output logic [31:0]      pres_o,
  output logic             fault_o
);

  logic [5:0] vld_q;
  logic [31:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q;
  logic [4:0]  f_q;
  logic [63:0] p0_q, p1_q, p2_q, p3_q;
  logic [63:0] ll_q, m8_q, sq_q, w2_q, w2b_q, m9_q, s_q;
  logic [31:0] hl_q;
  logic [31:0] pres_q;
  logic        fault_q;

  logic [63:0] ps_s, r_s;
  logic [31:0] sat_s;

  always_comb begin
    ps_s = 64'($signed(p0_q) >>> 13);
    r_s  = 64'($signed(s_q) >>> 8) + (64'(cal_i.p7) << 4);
    if (f_q[4] || r_s[63]) begin
      sat_s = '0;
    end else if (|r_s[62:32]) begin
      sat_s = '1;
    end else begin
      sat_s = r_s[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], beat_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= beat_i.neg ? 64'd0 - beat_i.num : beat_i.num;
    t0_q    <= beat_i.temp;
    f_q     <= {f_q[3:0], beat_i.fault};
    // square of the scaled pressure, low 64 bits from 32-bit halves
    ll_q    <= 64'(ps_s[31:0]) * 64'(ps_s[31:0]);
    hl_q    <= ps_s[63:32] * ps_s[31:0];
    m8_q    <= p0_q * 64'(cal_i.p8);
    p1_q    <= p0_q;
    t1_q    <= t0_q;
    sq_q    <= ll_q + {hl_q[30:0], 33'd0};
    w2_q    <= 64'($signed(m8_q) >>> 19);
    p2_q    <= p1_q;
    t2_q    <= t1_q;
    m9_q    <= sq_q * 64'(cal_i.p9);
    w2b_q   <= w2_q;
    p3_q    <= p2_q;
    t3_q    <= t2_q;
    s_q     <= p3_q + 64'($signed(m9_q) >>> 25) + w2b_q;
    t4_q    <= t3_q;
    pres_q  <= sat_s;
    fault_q <= f_q[4];
    t5_q    <= t4_q;
  end

  assign valid_o = vld_q[5];
  assign temp_o  = t5_q;
  assign pres_o  = pres_q;
  assign fault_o = fault_q;

endmodule

`default_nettype wire

// ===== rtl/core/baro_temp_pressure_compensation_core.sv =====
// Top level of the barometric temperature/pressure compensation core.
// Depends on bpc_pkg, bpc_front, bpc_div_cell and bpc_back.
//
// Usage:
//   Input beat: drive raw_temperature_i and raw_pressure_i with start_i high;
//   a beat is taken at every clock edge where start_i is high and busy_o is
//   low. busy_o never rises, so a new beat may enter on every cycle.
//   Result beat: valid_o pulses for one cycle with temperature_centi_o,
//   pressure_q24_8_o and divide_fault_o. The receiver cannot stall; results
//   leave in input order, one per accepted beat.
//   Path: from the accepting edge to the valid_o cycle a beat passes 9 front
//   stages (temperature, pressure numerator and denominator), a row of 64
//   division cells that each retire one quotient bit, then 6 back stages.
//   Throughput: one beat per cycle; every stage and cell moves each cycle.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//   Write only while no beat is in flight; unknown indexes are dropped.
//   Reset (rst_ni low, asynchronous) clears all coefficients to zero and
//   drops every beat in flight.
`default_nettype none

module baro_temp_pressure_compensation_core
  import bpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [RawW-1:0]     raw_temperature_i,
  input  wire logic [RawW-1:0]     raw_pressure_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     valid_o,
  output logic signed [31:0]       temperature_centi_o,
  output logic [31:0]              pressure_q24_8_o,
  output logic                     divide_fault_o
);

  // Calibration registers
  logic [15:0] cal_t1_q, cal_t2_q, cal_t3_q;
  logic [47:0] cal_pf_q, cal_pm_q, cal_pl_q;
  bpc_cal_t    cal_s;
  logic        accept_s;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept_s    = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t1_q <= '0;
      cal_t2_q <= '0;
      cal_t3_q <= '0;
      cal_pf_q <= '0;
      cal_pm_q <= '0;
      cal_pl_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_T1:       cal_t1_q <= cfg_data_i[15:0];
        CFG_T2:       cal_t2_q <= cfg_data_i[15:0];
        CFG_T3:       cal_t3_q <= cfg_data_i[15:0];
        CFG_P_FIRST:  cal_pf_q <= cfg_data_i;
        CFG_P_MIDDLE: cal_pm_q <= cfg_data_i;
        CFG_P_LAST:   cal_pl_q <= cfg_data_i;
        default:      ;  // drop writes to unused indexes
      endcase
    end
  end

  // Unpack the coefficient words, low field first
  always_comb begin
    cal_s.t1 = cal_t1_q;
    cal_s.t2 = cal_t2_q;
    cal_s.t3 = cal_t3_q;
    cal_s.p1 = cal_pf_q[15:0];
    cal_s.p2 = cal_pf_q[31:16];
    cal_s.p3 = cal_pf_q[47:32];
    cal_s.p4 = cal_pm_q[15:0];
    cal_s.p5 = cal_pm_q[31:16];
    cal_s.p6 = cal_pm_q[47:32];
    cal_s.p7 = cal_pl_q[15:0];
    cal_s.p8 = cal_pl_q[31:16];
    cal_s.p9 = cal_pl_q[47:32];
  end

  // Row of division cells; chain_s[k] feeds cell k
  bpc_div_t chain_s [DivSteps+1];

  bpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept_s),
    .raw_t_i (raw_temperature_i),
    .raw_p_i (raw_pressure_i),
    .cal_i   (cal_s),
    .head_o  (chain_s[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_cell
    bpc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain_s[k]),
      .beat_o (chain_s[k+1])
    );
  end

  logic [31:0] temp_s;

  bpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (chain_s[DivSteps]),
    .cal_i   (cal_s),
    .valid_o (valid_o),
    .temp_o  (temp_s),
    .pres_o  (pressure_q24_8_o),
    .fault_o (divide_fault_o)
  );

  assign temperature_centi_o = $signed(temp_s);

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for baro_temp_pressure_compensation_core.
// Holds a compensation predictor and a result scoreboard; depends on bpc_pkg.
`default_nettype none

module testbench;
  import bpc_pkg::*;

  // Register index that no coefficient uses
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  // Expected result of one beat
  typedef struct {
    logic [31:0] temp;
    logic [31:0] pres;
    logic        fault;
  } comp_result_t;

  // Scoreboard: predicts compensated results and checks them in order
  class comp_scoreboard;
    logic [15:0] t1, t2, t3;
    logic [47:0] p_first, p_middle, p_last;
    comp_result_t pending[$];
    int errors;
    int mismatches;

    function new();
      errors = 0;
      mismatches = 0;
      t1 = 0; t2 = 0; t3 = 0;
      p_first = 0; p_middle = 0; p_last = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] data);
      case (idx)
        CFG_T1: t1 = data[15:0];
        CFG_T2: t2 = data[15:0];
        CFG_T3: t3 = data[15:0];
        CFG_P_FIRST: p_first = data;
        CFG_P_MIDDLE: p_middle = data;
        CFG_P_LAST: p_last = data;
        default: ;
      endcase
    endfunction

    function comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      comp_result_t r;
      logic signed [31:0] a, b, v1t, v2t, fine, sq;
      logic signed [63:0] v1, v2, p, ps, w1, w2, q, an, ad;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      a = {12'd0, adc_t} >>> 3;
      a = a - ({16'd0, t1} << 1);
      a = a * 32'(signed'(t2));
      v1t = a >>> 11;
      b = ({12'd0, adc_t} >> 4) - {16'd0, t1};
      sq = b * b;
      sq = sq >>> 12;
      sq = sq * 32'(signed'(t3));
      v2t = sq >>> 14;
      fine = v1t + v2t;
      a = fine * 32'sd5 + 32'sd128;
      r.temp = a >>> 8;
      p1 = {48'd0, p_first[15:0]};
      p2 = 64'(signed'(p_first[31:16]));
      p3 = 64'(signed'(p_first[47:32]));
      p4 = 64'(signed'(p_middle[15:0]));
      p5 = 64'(signed'(p_middle[31:16]));
      p6 = 64'(signed'(p_middle[47:32]));
      p7 = 64'(signed'(p_last[15:0]));
      p8 = 64'(signed'(p_last[31:16]));
      p9 = 64'(signed'(p_last[47:32]));
      v1 = 64'(fine) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      w1 = v1 * v1 * p3;
      v1 = (w1 >>> 8) + ((v1 * p2) << 12);
      w1 = ((64'sd1 <<< 47) + v1) * p1;
      v1 = w1 >>> 33;
      r.pres = 0;
      r.fault = 0;
      if (v1 == 0) begin
        r.fault = 1;
      end else begin
        p = 64'sd1048576 - {44'd0, adc_p};
        p = ((p << 31) - v2) * 64'sd3125;
        // Truncating divide on magnitudes; the min / -1 case wraps naturally
        an = p[63] ? -p : p;
        ad = v1[63] ? -v1 : v1;
        q = $signed(64'($unsigned(an) / $unsigned(ad)));
        p = (p[63] != v1[63]) ? -q : q;
        ps = p >>> 13;
        w1 = p9 * ps * ps;
        w1 = w1 >>> 25;
        w2 = p8 * p;
        w2 = w2 >>> 19;
        q = p + w1 + w2;
        p = (q >>> 8) + (p7 << 4);
        if (p[63]) r.pres = 0;
        else if (p > 64'sh0_FFFF_FFFF) r.pres = 32'hFFFF_FFFF;
        else r.pres = p[31:0];
      end
      return r;
    endfunction

    function void note_input(logic [19:0] adc_t, logic [19:0] adc_p);
      pending.push_back(compensate(adc_t, adc_p));
    endfunction

    function void check_result(logic [31:0] temp, logic [31:0] pres, logic fault);
      comp_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result temp=%h pres=%h", temp, pres);
        return;
      end
      e = pending.pop_front();
      if (e.temp !== temp || e.pres !== pres || e.fault !== fault) begin
        errors++;
        if (mismatches++ < 10)
          $display("bad result: exp t=%h p=%h f=%b got t=%h p=%h f=%b",
                   e.temp, e.pres, e.fault, temp, pres, fault);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic [RawW-1:0] raw_temperature_i = 0;
  logic [RawW-1:0] raw_pressure_i = 0;
  logic cfg_valid_i = 0;
  logic [CfgIdxW-1:0] cfg_index_i = 0;
  logic [CfgDataW-1:0] cfg_data_i = 0;
  logic busy_o, cfg_ready_o, valid_o, divide_fault_o;
  logic signed [31:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;

  comp_scoreboard sb = new();

  baro_temp_pressure_compensation_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .raw_temperature_i, .raw_pressure_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .valid_o,
    .temperature_centi_o, .pressure_q24_8_o, .divide_fault_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Check every result beat at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_result(temperature_centi_o, pressure_q24_8_o, divide_fault_o);
  end

  // Hard limit on run time
  initial begin
    #4000000;
    $display("baro_temp_pressure_compensation_core: mismatch");
    $finish;
  end

  // Random gap length: mostly short, now and then long
  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // Write one register; hold valid until ready takes the beat
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [47:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Send one input beat and record its prediction when taken
  task automatic send_beat(logic [19:0] adc_t, logic [19:0] adc_p, bit gaps);
    int n;
    start_i <= 1;
    raw_temperature_i <= adc_t;
    raw_pressure_i <= adc_p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(adc_t, adc_p);
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 2) != 0) begin
      n = gap_len();
      if (n > 0) begin
        start_i <= 0;
        repeat (n) @(negedge clk_i);
      end
    end
  endtask

  // Drain the pipeline before touching the registers
  task automatic drain();
    start_i <= 0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Program a datasheet-like calibration set as is or with random jitter, raw random or extreme values
  task automatic program_cal(int mode);
    logic [15:0] c[12];
    c = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
          16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
    for (int i = 0; i < 12; i++) begin
      if (mode == 1) c[i] = c[i] + 16'($urandom_range(0, 63)) - 16'd32;
      else if (mode == 2) c[i] = 16'($urandom);
      else if (mode == 3) c[i] = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h8000;
      else if (mode == 4) c[i] = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h0000;
    end
    write_cfg(CFG_T1, {$urandom, c[0]});
    write_cfg(CFG_T2, {32'h0, c[1]});
    write_cfg(CFG_T3, {32'h0, c[2]});
    write_cfg(CFG_P_FIRST, {c[5], c[4], c[3]});
    write_cfg(CFG_P_MIDDLE, {c[8], c[7], c[6]});
    write_cfg(CFG_P_LAST, {c[11], c[10], c[9]});
    // Unknown index must be dropped
    write_cfg(CfgUnused, 48'($urandom));
    cfg_valid_i <= 0;
  endtask

  task automatic random_beat();
    logic [19:0] t, p;
    t = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'd519888 + 20'($urandom_range(0, 65535)) - 20'd32768;
    p = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'd415148 + 20'($urandom_range(0, 131071)) - 20'd65536;
    send_beat(t, p, 1);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Reset coefficients: denominator is zero, so every beat faults
    send_beat(20'd0, 20'd0, 0);
    send_beat(20'hFFFFF, 20'hFFFFF, 0);
    drain();

    // Directed extremes under nominal, then extreme calibrations
    program_cal(0);
    send_beat(20'd519888, 20'd415148, 0);
    send_beat(20'd0, 20'd0, 0);
    send_beat(20'hFFFFF, 20'hFFFFF, 0);
    send_beat(20'd0, 20'hFFFFF, 0);
    send_beat(20'hFFFFF, 20'd0, 0);
    send_beat(20'h55555, 20'hAAAAA, 0);
    send_beat(20'hAAAAA, 20'h55555, 0);
    drain();
    program_cal(3);
    send_beat(20'd0, 20'd0, 0);
    send_beat(20'hFFFFF, 20'hFFFFF, 0);
    send_beat(20'd519888, 20'd415148, 0);
    drain();
    program_cal(4);
    send_beat(20'd0, 20'hFFFFF, 0);
    send_beat(20'hFFFFF, 20'd0, 0);
    send_beat(20'd519888, 20'd415148, 0);
    drain();

    // Random phases over several calibrations
    for (int ph = 0; ph < 7; ph++) begin
      program_cal(ph == 6 ? 2 : (ph % 3 == 0 ? 0 : ((ph % 3 == 1) ? 1 : 2)));
      for (int i = 0; i < 100; i++) begin
        random_beat();
        // Hold off once until the pipeline is empty
        if (ph == 1 && i == 50) begin
          start_i <= 0;
          while (sb.pending.size() != 0) @(negedge clk_i);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("baro_temp_pressure_compensation_core: match");
    else
      $display("baro_temp_pressure_compensation_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== baro_temp_pressure_compensation_core.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_front.sv
rtl/core/bpc_div_cell.sv
rtl/core/bpc_back.sv
rtl/core/baro_temp_pressure_compensation_core.sv
dv/testbench.sv
